### design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clk edge outside reset
`define CHK_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/cmbsu_pkg.sv
// shared types, constants and helper functions of the clipmap slot updater
package cmbsu_pkg;

	localparam int LEVELS    = 8;
	localparam int SIDE      = 6;
	localparam int SLOTS     = SIDE * SIDE;
	localparam int MEM_DEPTH = LEVELS * SLOTS;
	localparam int LVL_W     = 3;
	localparam int SLOT_W    = 6;
	localparam int ADDR_W    = 9;
	localparam int GRID_W    = 24;
	localparam int WIN_W     = 25;
	localparam int BLK_W     = 26;
	localparam int BSL_W     = 4;
	localparam int SH_W      = 5;
	localparam logic [BSL_W-1:0] BSL_RESET = 4'd5;
	localparam logic [SLOT_W-1:0] SLOT_LAST = 6'd35;
	localparam logic [SLOT_W-1:0] SCAN_END  = 6'd36;
	localparam logic REQ_INIT = 1'b0;

	typedef struct packed {
		logic load;
		logic clr;
		logic save;
		logic init_step;
		logic scan_step;
		logic pair_step;
	} cmd_t;

	typedef struct packed {
		logic is_init;
		logic grid_same;
		logic init_end;
		logic scan_end;
		logic pair_empty;
		logic pair_last;
	} stat_t;

	// row of a slot within the 6x6 window
	function automatic logic [2:0] pos_y(input logic [SLOT_W-1:0] i);
		logic [2:0] y;
		if (i >= 6'd30) y = 3'd5;
		else if (i >= 6'd24) y = 3'd4;
		else if (i >= 6'd18) y = 3'd3;
		else if (i >= 6'd12) y = 3'd2;
		else if (i >= 6'd6) y = 3'd1;
		else y = 3'd0;
		return y;
	endfunction

	// column of a slot within the 6x6 window
	function automatic logic [2:0] pos_x(input logic [SLOT_W-1:0] i);
		logic [SLOT_W-1:0] y6;
		logic [SLOT_W-1:0] t;
		y6 = ({3'b0, pos_y(i)} << 2) + ({3'b0, pos_y(i)} << 1);
		t = i - y6;
		return t[2:0];
	endfunction

	// inner 3x3 membership, offset is 1 plus grid parity
	function automatic logic inner_at(input logic [2:0] x, input logic [2:0] y,
		input logic px, input logic py);
		logic [2:0] ox;
		logic [2:0] oy;
		ox = 3'd1 + {2'b0, px};
		oy = 3'd1 + {2'b0, py};
		return (x >= ox) && (x <= ox + 3'd2) && (y >= oy) && (y <= oy + 3'd2);
	endfunction

endpackage

### design/clipmap_block_slot_update.sv
// top level of the clipmap block slot updater
// Usage: write block_size_log2 through cfg_we/cfg_wdata while idle (reset value 5).
// Raise start with req_type, level, cam_x, cam_z; the item is taken when busy is low.
// Init (req_type 0) writes all 36 slots of the level and emits each one, slot 0..35.
// Update (req_type 1) emits one result per rewritten slot, none if the grid is unchanged.
// Each result sits on the result ports for one cycle with valid high; last marks the final.
// Init passes through the item latch and the CALC state, then emits one result per cycle.
// Update passes through the same setup, then a slot scan (one memory read per cycle through
// the registered read port of the slot store), then one rewrite per cycle.
// An unchanged grid returns to idle from CALC. busy stays high until the item is finished.
// The receiver cannot stall: results are never held back.
// Reset clears the controller and the saved grid of every level and resets the register; the
// slot store is not cleared, and each level must be initialized before updating it.
module clipmap_block_slot_update (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             cfg_we,
	input  logic [cmbsu_pkg::BSL_W-1:0]      cfg_wdata,
	input  logic                             req_type,
	input  logic [cmbsu_pkg::LVL_W-1:0]      level,
	input  logic [cmbsu_pkg::GRID_W-1:0]     cam_x,
	input  logic [cmbsu_pkg::GRID_W-1:0]     cam_z,
	output logic                             valid,
	output logic [cmbsu_pkg::SLOT_W-1:0]     slot,
	output logic signed [cmbsu_pkg::BLK_W-1:0] block_x,
	output logic signed [cmbsu_pkg::BLK_W-1:0] block_y,
	output logic                             inner,
	output logic signed [cmbsu_pkg::WIN_W-1:0] window_x,
	output logic signed [cmbsu_pkg::WIN_W-1:0] window_y,
	output logic                             last
);
	import cmbsu_pkg::*;
	`include "assert_macros.svh"

	cmd_t  cmd;
	stat_t stat;

	// controller
	cmbsu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath
	cmbsu_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_type  (req_type),
		.level     (level),
		.cam_x     (cam_x),
		.cam_z     (cam_z),
		.valid     (valid),
		.slot      (slot),
		.block_x   (block_x),
		.block_y   (block_y),
		.inner     (inner),
		.window_x  (window_x),
		.window_y  (window_y),
		.last      (last)
	);

	// checks
	`CHK_NEXT(a_start_busy, start && !busy, busy, "accepted item did not raise busy")
	`CHK_NEXT(a_last_gap, valid && last, !valid, "result follows the last one")
	`CHK_IMPL(a_slot_range, valid, slot <= SLOT_LAST, "slot number out of range")
	`CHK_IMPL(a_one_step, busy, $onehot0({cmd.init_step, cmd.scan_step, cmd.pair_step}),
		"more than one datapath step at once")

endmodule

### design/cmbsu_ctrl.sv
// sequencing state machine of the clipmap slot updater
module cmbsu_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cmbsu_pkg::stat_t stat,
	output cmbsu_pkg::cmd_t  cmd,
	output logic          busy
);
	import cmbsu_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CALC = 5'b00010,
		ST_INIT = 5'b00100,
		ST_SCAN = 5'b01000,
		ST_PAIR = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_CALC;
			ST_CALC: begin
				if (stat.is_init) state_d = ST_INIT;
				else if (stat.grid_same) state_d = ST_IDLE;
				else state_d = ST_SCAN;
			end
			ST_INIT: if (stat.init_end) state_d = ST_IDLE;
			ST_SCAN: if (stat.scan_end) state_d = ST_PAIR;
			ST_PAIR: if (stat.pair_empty || stat.pair_last) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// datapath commands
	always_comb begin
		cmd.load      = (state_q == ST_IDLE) && start;
		cmd.clr       = (state_q == ST_CALC);
		cmd.save      = (state_q == ST_CALC) && (stat.is_init || !stat.grid_same);
		cmd.init_step = (state_q == ST_INIT);
		cmd.scan_step = (state_q == ST_SCAN);
		cmd.pair_step = (state_q == ST_PAIR) && !stat.pair_empty;
	end

	assign busy = (state_q != ST_IDLE);

endmodule

### design/cmbsu_dp.sv
// datapath: grid math, slot memory, match scan, pairing and result registers
module cmbsu_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cmbsu_pkg::cmd_t                  cmd,
	output cmbsu_pkg::stat_t                 stat,
	input  logic                             cfg_we,
	input  logic [cmbsu_pkg::BSL_W-1:0]      cfg_wdata,
	input  logic                             req_type,
	input  logic [cmbsu_pkg::LVL_W-1:0]      level,
	input  logic [cmbsu_pkg::GRID_W-1:0]     cam_x,
	input  logic [cmbsu_pkg::GRID_W-1:0]     cam_z,
	output logic                             valid,
	output logic [cmbsu_pkg::SLOT_W-1:0]     slot,
	output logic signed [cmbsu_pkg::BLK_W-1:0] block_x,
	output logic signed [cmbsu_pkg::BLK_W-1:0] block_y,
	output logic                             inner,
	output logic signed [cmbsu_pkg::WIN_W-1:0] window_x,
	output logic signed [cmbsu_pkg::WIN_W-1:0] window_y,
	output logic                             last
);
	import cmbsu_pkg::*;

	localparam int MW = 2 * BLK_W + 1;

	logic [BSL_W-1:0]  bsl_q;
	logic              req_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [GRID_W-1:0] gx_q, gy_q;
	logic [GRID_W-1:0] saved_gx_q [LEVELS];
	logic [GRID_W-1:0] saved_gy_q [LEVELS];
	logic [SLOT_W-1:0] cnt_q;
	logic [SLOTS-1:0]  stale_q, fresh_q;
	logic [MW-1:0]     mem [MEM_DEPTH];
	logic [MW-1:0]     rdata_q;

	logic [SH_W-1:0]   sh;
	logic [WIN_W-1:0]  wx, wy;
	logic [BLK_W-1:0]  wx_e, wy_e;
	logic [ADDR_W-1:0] base;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [MW-1:0]     wdata;
	logic [ADDR_W-1:0] raddr;

	// scan-side decode
	logic [BLK_W-1:0]  rd_bx, rd_by, dx, dy;
	logic              rd_inn, hit;
	logic [SLOT_W-1:0] hit_j, scan_i;

	// pairing
	logic [SLOT_W-1:0] s_idx, a_idx;
	logic [SLOTS-1:0]  stale_rest, fresh_rest;

	// emitted result
	logic [SLOT_W-1:0] e_slot;
	logic [2:0]        e_x, e_y;
	logic [BLK_W-1:0]  e_bx, e_by;
	logic              e_inn, e_last, e_valid;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bsl_q <= BSL_RESET;
		else if (cfg_we) bsl_q <= cfg_wdata;
	end

	// latch the item and its grid index
	assign sh = {1'b0, bsl_q} + {2'b0, level};
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			lvl_q <= level;
			gx_q  <= cam_x >> sh;
			gy_q  <= cam_z >> sh;
		end
	end

	// window start and memory base of the level
	assign wx   = {1'b0, gx_q[GRID_W-1:1], 1'b0} - WIN_W'(2);
	assign wy   = {1'b0, gy_q[GRID_W-1:1], 1'b0} - WIN_W'(2);
	assign wx_e = {wx[WIN_W-1], wx};
	assign wy_e = {wy[WIN_W-1], wy};
	assign base = ({1'b0, lvl_q, 5'b0}) + ({4'b0, lvl_q, 2'b0});

	// saved grid per level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				saved_gx_q[i] <= '0;
				saved_gy_q[i] <= '0;
			end
		end else if (cmd.save) begin
			saved_gx_q[lvl_q] <= gx_q;
			saved_gy_q[lvl_q] <= gy_q;
		end
	end

	// step counter for init and scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (cmd.clr) cnt_q <= '0;
		else if (cmd.init_step || cmd.scan_step) cnt_q <= cnt_q + SLOT_W'(1);
	end

	// decode one stored slot against the new window
	assign rd_bx  = rdata_q[MW-1:BLK_W+1];
	assign rd_by  = rdata_q[BLK_W:1];
	assign rd_inn = rdata_q[0];
	assign dx     = rd_bx - wx_e;
	assign dy     = rd_by - wy_e;
	assign hit    = (dx < BLK_W'(SIDE)) && (dy < BLK_W'(SIDE)) &&
		(rd_inn == inner_at(dx[2:0], dy[2:0], gx_q[0], gy_q[0]));
	assign hit_j  = ({3'b0, dy[2:0]} << 2) + ({3'b0, dy[2:0]} << 1) + {3'b0, dx[2:0]};
	assign scan_i = cnt_q - SLOT_W'(1);

	// first stale slot and first fresh block
	always_comb begin
		s_idx = '0;
		a_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (stale_q[i]) s_idx = SLOT_W'(i);
			if (fresh_q[i]) a_idx = SLOT_W'(i);
		end
	end
	assign stale_rest = stale_q & (stale_q - SLOTS'(1));
	assign fresh_rest = fresh_q & (fresh_q - SLOTS'(1));

	// stale and fresh vectors
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			stale_q <= '1;
			fresh_q <= '1;
		end else if (cmd.scan_step && cnt_q != '0 && hit) begin
			stale_q[scan_i] <= 1'b0;
			fresh_q[hit_j]  <= 1'b0;
		end else if (cmd.pair_step) begin
			stale_q <= stale_rest;
			fresh_q <= fresh_rest;
		end
	end

	// result selection for init and pairing
	always_comb begin
		e_valid = cmd.init_step || cmd.pair_step;
		if (cmd.init_step) begin
			e_slot = cnt_q;
			e_x    = pos_x(cnt_q);
			e_y    = pos_y(cnt_q);
			e_last = (cnt_q == SLOT_LAST);
		end else begin
			e_slot = s_idx;
			e_x    = pos_x(a_idx);
			e_y    = pos_y(a_idx);
			e_last = (stale_rest == '0) || (fresh_rest == '0);
		end
		e_bx  = wx_e + {{(BLK_W-3){1'b0}}, e_x};
		e_by  = wy_e + {{(BLK_W-3){1'b0}}, e_y};
		e_inn = inner_at(e_x, e_y, gx_q[0], gy_q[0]);
	end

	// slot memory ports
	assign we    = e_valid;
	assign waddr = base + {3'b0, e_slot};
	assign wdata = {e_bx, e_by, e_inn};
	assign raddr = base + {3'b0, cnt_q};

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid <= 1'b0;
		else valid <= e_valid;
	end
	always_ff @(posedge clk) begin
		if (e_valid) begin
			slot     <= e_slot;
			block_x  <= e_bx;
			block_y  <= e_by;
			inner    <= e_inn;
			window_x <= wx;
			window_y <= wy;
			last     <= e_last;
		end
	end

	// status to the controller
	always_comb begin
		stat.is_init    = (req_q == REQ_INIT);
		stat.grid_same  = (saved_gx_q[lvl_q] == gx_q) && (saved_gy_q[lvl_q] == gy_q);
		stat.init_end   = (cnt_q == SLOT_LAST);
		stat.scan_end   = (cnt_q == SCAN_END);
		stat.pair_empty = (stale_q == '0) || (fresh_q == '0);
		stat.pair_last  = (stale_rest == '0) || (fresh_rest == '0);
	end

endmodule
